FILE: hw/rtl/mips_pkg.sv
// types and constants shared by the motion inactivity power state block
`timescale 1ns / 1ps

package mips_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int TOD_WIDTH    = 17;
  localparam int THR_WIDTH    = 16;
  localparam int CFG_WIDTH    = 17;
  localparam int CFG_IDX_W    = 2;

  localparam logic [TOD_WIDTH-1:0] SECONDS_PER_HOUR   = 17'd3600;
  localparam logic [TOD_WIDTH-1:0] SECONDS_PER_MINUTE = 17'd60;
  localparam logic [TOD_WIDTH-1:0] SECONDS_PER_DAY    = 17'd86400;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_FORCE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_TIMEOUT     = 2'd2;

  localparam logic [THR_WIDTH-1:0] THRESHOLD_RESET     = 16'd410;
  localparam logic [TOD_WIDTH-1:0] LIGHT_TIMEOUT_RESET = 17'd30;
  localparam logic [TOD_WIDTH-1:0] DEEP_TIMEOUT_RESET  = 17'd300;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_SLEEP  = 2'd1,
    MODE_DEEP   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]                     operation;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic [4:0]                     clock_hour;
    logic [5:0]                     clock_minute;
    logic [5:0]                     clock_second;
    logic [1:0]                     forced_state;
  } in_req_t;

  typedef struct packed {
    logic                 motion_seen;
    logic [1:0]           power_state;
    logic                 state_changed;
    logic [TOD_WIDTH-1:0] idle_seconds;
  } out_rsp_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] prev_x;
    logic signed [SAMPLE_WIDTH-1:0] prev_y;
    logic signed [SAMPLE_WIDTH-1:0] prev_z;
    logic [TOD_WIDTH-1:0]           last_motion_sod;
    mode_t                          mode;
  } track_t;

  typedef struct packed {
    logic [THR_WIDTH-1:0] motion_thr;
    logic [TOD_WIDTH-1:0] light_idle_limit;
    logic [TOD_WIDTH-1:0] deep_idle_limit;
  } cfg_t;

endpackage

FILE: hw/rtl/mips_step.sv
// single-request evaluation: motion detect, idle time and power state update
`timescale 1ns / 1ps

module mips_step (
  input  mips_pkg::in_req_t  req,
  input  mips_pkg::track_t   track,
  input  mips_pkg::cfg_t     cfg,
  output mips_pkg::track_t   track_nxt,
  output mips_pkg::out_rsp_t rsp
);

  localparam int SW = mips_pkg::SAMPLE_WIDTH;
  localparam int TW = mips_pkg::TOD_WIDTH;

  function automatic logic axis_moved(input logic [SW-1:0] now_v,
                                      input logic [SW-1:0] before_v,
                                      input logic [mips_pkg::THR_WIDTH-1:0] thr);
    logic [SW:0] diff;
    logic [SW:0] mag;
    diff = {now_v[SW-1], now_v} - {before_v[SW-1], before_v};
    mag  = diff[SW] ? ((~diff) + {{SW{1'b0}}, 1'b1}) : diff;
    return 64'(mag) > 64'(thr);
  endfunction

  logic [TW-1:0] tod_raw;
  logic [TW-1:0] tod;
  logic          moved;
  logic [TW-1:0] idle;

  // time of day, at most one day over even for out of range fields
  assign tod_raw = TW'(req.clock_hour) * mips_pkg::SECONDS_PER_HOUR
                 + TW'(req.clock_minute) * mips_pkg::SECONDS_PER_MINUTE
                 + TW'(req.clock_second);
  assign tod = (tod_raw >= mips_pkg::SECONDS_PER_DAY) ?
               tod_raw - mips_pkg::SECONDS_PER_DAY : tod_raw;

  assign moved = axis_moved(req.accel_x, track.prev_x, cfg.motion_thr)
              || axis_moved(req.accel_y, track.prev_y, cfg.motion_thr)
              || axis_moved(req.accel_z, track.prev_z, cfg.motion_thr);

  // idle time with day wraparound
  assign idle = (tod >= track.last_motion_sod) ? tod - track.last_motion_sod
              : (mips_pkg::SECONDS_PER_DAY - track.last_motion_sod) + tod;

  always_comb begin
    track_nxt         = track;
    rsp.motion_seen   = 1'b0;
    rsp.state_changed = 1'b0;
    rsp.idle_seconds  = '0;
    case (req.operation)
      mips_pkg::OP_SAMPLE: begin
        track_nxt.prev_x = req.accel_x;
        track_nxt.prev_y = req.accel_y;
        track_nxt.prev_z = req.accel_z;
        if (moved) begin
          rsp.motion_seen           = 1'b1;
          track_nxt.last_motion_sod = tod;
          if (track.mode == mips_pkg::MODE_SLEEP) begin
            track_nxt.mode    = mips_pkg::MODE_ACTIVE;
            rsp.state_changed = 1'b1;
          end
        end else begin
          rsp.idle_seconds = idle;
          if (track.mode == mips_pkg::MODE_ACTIVE && idle >= cfg.light_idle_limit) begin
            track_nxt.mode    = mips_pkg::MODE_SLEEP;
            rsp.state_changed = 1'b1;
          end else if (track.mode == mips_pkg::MODE_SLEEP &&
                       idle >= cfg.deep_idle_limit) begin
            track_nxt.mode    = mips_pkg::MODE_DEEP;
            rsp.state_changed = 1'b1;
          end
        end
      end
      mips_pkg::OP_START: begin
        track_nxt.prev_x          = req.accel_x;
        track_nxt.prev_y          = req.accel_y;
        track_nxt.prev_z          = req.accel_z;
        track_nxt.last_motion_sod = tod;
      end
      mips_pkg::OP_FORCE: begin
        case (req.forced_state)
          mips_pkg::MODE_ACTIVE: track_nxt.mode = mips_pkg::MODE_ACTIVE;
          mips_pkg::MODE_SLEEP:  track_nxt.mode = mips_pkg::MODE_SLEEP;
          mips_pkg::MODE_DEEP:   track_nxt.mode = mips_pkg::MODE_DEEP;
          default:               track_nxt.mode = track.mode;
        endcase
      end
      default: begin
        track_nxt = track;
      end
    endcase
    rsp.power_state = track_nxt.mode;
  end

endmodule

FILE: hw/rtl/motion_inactivity_power_state.sv
// top level of the accelerometer motion / inactivity power state tracker
`timescale 1ns / 1ps

// usage
//   in_* channel: one request per accepted in_valid/in_ready, carrying the
//   operation code, three signed accelerometer samples, the rtc time of day
//   and a force target
//   out_* channel: exactly one response per request, in request order
//   cfg_* port: write-only registers, index 0 motion threshold, 1 light
//   sleep timeout, 2 deep sleep timeout; write only while the block is idle
// timing
//   a request is captured into an input register, then evaluated by
//   combinational compare/subtract logic into the response register,
//   from which the response is offered
//   throughput is one request per cycle while out_ready stays high, set by
//   the single evaluation stage that also updates the tracking state
//   (baseline samples, last motion second of day, power mode)
// reset
//   synchronous active low; mode goes to active, baseline and last motion
//   time to zero, registers to their defaults, both channels empty
// stalls
//   when out_ready is low the response register holds; the input register
//   still takes one more request, after which in_ready drops

module motion_inactivity_power_state (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mips_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mips_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mips_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mips_pkg::CFG_WIDTH-1:0]      cfg_data
);

  // input register
  logic               req_valid_r;
  mips_pkg::in_req_t  req_r;

  // response register
  logic               rsp_valid_r;
  mips_pkg::out_rsp_t rsp_r;

  // tracking state and configuration
  mips_pkg::track_t   track_r;
  mips_pkg::track_t   track_nxt;
  mips_pkg::cfg_t     cfg_r;
  mips_pkg::out_rsp_t rsp_nxt;

  logic advance;
  logic take_in;

  // evaluate the held request when the response register is free or draining
  assign advance  = req_valid_r && (!rsp_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;
  assign take_in  = in_valid && in_ready;

  assign out_valid = rsp_valid_r;
  assign out_data  = rsp_r;

  mips_step u_step (
    .req       (req_r),
    .track     (track_r),
    .cfg       (cfg_r),
    .track_nxt (track_nxt),
    .rsp       (rsp_nxt)
  );

  // handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (take_in) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        rsp_valid_r <= 1'b1;
      end else if (out_ready) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      req_r <= in_data;
    end
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  // tracking state moves only when a request is evaluated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r.prev_x          <= '0;
      track_r.prev_y          <= '0;
      track_r.prev_z          <= '0;
      track_r.last_motion_sod <= '0;
      track_r.mode            <= mips_pkg::MODE_ACTIVE;
    end else if (advance) begin
      track_r <= track_nxt;
    end
  end

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_thr       <= mips_pkg::THRESHOLD_RESET;
      cfg_r.light_idle_limit <= mips_pkg::LIGHT_TIMEOUT_RESET;
      cfg_r.deep_idle_limit  <= mips_pkg::DEEP_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mips_pkg::CFG_MOTION_THRESHOLD:
          cfg_r.motion_thr <= cfg_data[mips_pkg::THR_WIDTH-1:0];
        mips_pkg::CFG_LIGHT_TIMEOUT:
          cfg_r.light_idle_limit <= cfg_data[mips_pkg::TOD_WIDTH-1:0];
        mips_pkg::CFG_DEEP_TIMEOUT:
          cfg_r.deep_idle_limit <= cfg_data[mips_pkg::TOD_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // motion always zeroes the idle count
  a_motion_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.motion_seen |-> out_data.idle_seconds == '0)
    else $error("idle count nonzero on a motion response");

  // a change caused by motion can only be a wake to active
  a_motion_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.state_changed && out_data.motion_seen
    |-> out_data.power_state == mips_pkg::MODE_ACTIVE)
    else $error("motion change did not land in active");

  // an idle change always moves away from active
  a_idle_falls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.state_changed && !out_data.motion_seen
    |-> out_data.power_state != mips_pkg::MODE_ACTIVE)
    else $error("idle change landed in active");

  // idle time stays within one day
  a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.idle_seconds < mips_pkg::SECONDS_PER_DAY)
    else $error("idle count beyond one day");

  // an evaluated request always shows up as a response next cycle
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid && out_data.power_state == $past(track_nxt.mode))
    else $error("evaluated request lost");

endmodule

FILE: verif/motion_inactivity_power_state_tb.sv
// self-checking testbench for the motion inactivity power state block
`timescale 1ns / 1ps

module motion_inactivity_power_state_tb;
  import mips_pkg::*;

  // codes the package leaves unnamed but the fields can still carry
  localparam logic [1:0]           OP_UNUSED      = 2'd3;
  localparam logic [1:0]           MODE_UNDEFINED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;

  localparam int RANDOM_PHASES    = 8;
  localparam int RANDOM_PER_PHASE = 106;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_req_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_rsp_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;

  // requests waiting for the driver, and responses the block still owes
  in_req_t  req_backlog[$];
  out_rsp_t power_rsp_due[$];

  // predictor copy of the tracking state and of the registers
  track_t tracker;
  cfg_t   mdl_regs;

  // generator side: last samples handed to the block and a running rtc
  logic signed [SAMPLE_WIDTH-1:0] sent_axis [3];
  int                             clock_sod = 0;

  int       mismatches = 0;
  int       burst_left = 0;
  int       gap_left   = 0;
  int       ready_left = 4;
  out_rsp_t want;

  motion_inactivity_power_state dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // strict compare: a delta equal to the threshold is not motion
  function automatic logic axis_moved(logic signed [SAMPLE_WIDTH-1:0] cur_v,
                                      logic signed [SAMPLE_WIDTH-1:0] prev_v);
    int d;
    d = int'(cur_v) - int'(prev_v);
    if (d < 0) d = -d;
    return d > int'(mdl_regs.motion_thr);
  endfunction

  // apply one request to the tracking state, return the response it earns
  function automatic out_rsp_t advance_power_state(in_req_t req);
    out_rsp_t rsp;
    int       sod;
    int       idle;
    logic     moved;
    rsp = '0;
    // rtc fields may be out of range; one day off is always enough
    sod = int'(req.clock_hour) * int'(SECONDS_PER_HOUR)
        + int'(req.clock_minute) * int'(SECONDS_PER_MINUTE)
        + int'(req.clock_second);
    if (sod >= int'(SECONDS_PER_DAY)) sod -= int'(SECONDS_PER_DAY);
    case (req.operation)
      OP_SAMPLE: begin
        moved = axis_moved(req.accel_x, tracker.prev_x)
              | axis_moved(req.accel_y, tracker.prev_y)
              | axis_moved(req.accel_z, tracker.prev_z);
        tracker.prev_x = req.accel_x;
        tracker.prev_y = req.accel_y;
        tracker.prev_z = req.accel_z;
        if (moved) begin
          // motion wakes sleep only; active and deep sleep keep their mode
          rsp.motion_seen = 1'b1;
          tracker.last_motion_sod = TOD_WIDTH'(sod);
          if (tracker.mode == MODE_SLEEP) begin
            tracker.mode = MODE_ACTIVE;
            rsp.state_changed = 1'b1;
          end
        end else begin
          // idle time across midnight
          if (sod >= int'(tracker.last_motion_sod))
            idle = sod - int'(tracker.last_motion_sod);
          else
            idle = int'(SECONDS_PER_DAY) - int'(tracker.last_motion_sod) + sod;
          rsp.idle_seconds = TOD_WIDTH'(idle);
          // at most one step down per request
          if (tracker.mode == MODE_ACTIVE &&
              idle >= int'(mdl_regs.light_idle_limit)) begin
            tracker.mode = MODE_SLEEP;
            rsp.state_changed = 1'b1;
          end else if (tracker.mode == MODE_SLEEP &&
                       idle >= int'(mdl_regs.deep_idle_limit)) begin
            tracker.mode = MODE_DEEP;
            rsp.state_changed = 1'b1;
          end
        end
      end
      OP_START: begin
        // new baseline, mode kept
        tracker.prev_x = req.accel_x;
        tracker.prev_y = req.accel_y;
        tracker.prev_z = req.accel_z;
        tracker.last_motion_sod = TOD_WIDTH'(sod);
      end
      OP_FORCE: begin
        // a target of three is dropped
        if (req.forced_state <= MODE_DEEP) tracker.mode = mode_t'(req.forced_state);
      end
      default: ;
    endcase
    rsp.power_state = tracker.mode;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of requests with random gaps, prediction at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) power_rsp_due.push_back(advance_power_state(in_data));
      // a request still waiting for ready stays as it is
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= req_backlog.pop_front();
          if (burst_left <= 1) begin
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 64 : 6);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                         $urandom_range(1, ($urandom_range(0, 4) == 0) ? 15 : 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: alternating ready and stall runs of random length
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      ready_left = 4;
    end else if (ready_left == 0) begin
      out_ready <= !out_ready;
      if (out_ready)
        ready_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4);
      else
        ready_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 10);
    end else begin
      ready_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every response against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string why, input out_rsp_t exp_rsp);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected motion=%0d state=%0d changed=%0d idle=%0d",
               $time, why, exp_rsp.motion_seen, exp_rsp.power_state,
               exp_rsp.state_changed, exp_rsp.idle_seconds,
               "  got motion=%0d state=%0d changed=%0d idle=%0d",
               out_data.motion_seen, out_data.power_state,
               out_data.state_changed, out_data.idle_seconds);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (power_rsp_due.size() == 0) begin
        report_mismatch("response with no request outstanding", '0);
      end else begin
        want = power_rsp_due.pop_front();
        if (out_data.motion_seen   !== want.motion_seen   ||
            out_data.power_state   !== want.power_state   ||
            out_data.state_changed !== want.state_changed ||
            out_data.idle_seconds  !== want.idle_seconds)
          report_mismatch("response mismatch", want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op,
                          input logic signed [SAMPLE_WIDTH-1:0] ax,
                          input logic signed [SAMPLE_WIDTH-1:0] ay,
                          input logic signed [SAMPLE_WIDTH-1:0] az,
                          input logic [4:0] hr, input logic [5:0] mn,
                          input logic [5:0] sc, input logic [1:0] target);
    in_req_t req;
    req = '{op, ax, ay, az, hr, mn, sc, target};
    // keep track of the baseline the block will compare against
    if (op == OP_SAMPLE || op == OP_START) begin
      sent_axis[0] = ax;
      sent_axis[1] = ay;
      sent_axis[2] = az;
    end
    req_backlog.push_back(req);
  endtask

  // register writes go out only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_MOTION_THRESHOLD: mdl_regs.motion_thr       = value[THR_WIDTH-1:0];
      CFG_LIGHT_TIMEOUT:    mdl_regs.light_idle_limit = value;
      CFG_DEEP_TIMEOUT:     mdl_regs.deep_idle_limit  = value;
      default: ;
    endcase
  endtask

  // every request sent and answered, plus slack for the two-stage pipe
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || power_rsp_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                             step_max;
    int                             kind;
    int                             step;
    int                             q;
    int                             r;
    int                             a;
    int                             lt;
    logic [1:0]                     op;
    logic [4:0]                     hr;
    logic [5:0]                     mn;
    logic [5:0]                     sc;
    logic signed [SAMPLE_WIDTH-1:0] axis [3];

    tracker  = '0;
    mdl_regs = '{THRESHOLD_RESET, LIGHT_TIMEOUT_RESET, DEEP_TIMEOUT_RESET};
    sent_axis[0] = '0;
    sent_axis[1] = '0;
    sent_axis[2] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset register values: threshold 410,
    // light timeout 30, deep timeout 300
    push_req(OP_START,  0,   0, 0, 0, 0, 0, MODE_ACTIVE);
    // delta equal to the threshold is quiet, one more is motion
    push_req(OP_SAMPLE, 410, 0, 0, 0, 0, 10, MODE_ACTIVE);
    push_req(OP_SAMPLE, 821, 0, 0, 0, 0, 20, MODE_ACTIVE);
    // idle reaches the light timeout exactly
    push_req(OP_SAMPLE, 821, 0, 0, 0, 0, 50, MODE_ACTIVE);
    // full-scale swings wake sleep, then motion while active
    push_req(OP_SAMPLE, 821, 0, 16'sh8000, 0, 1, 0, MODE_ACTIVE);
    push_req(OP_SAMPLE, 821, 0, 16'sh7FFF, 0, 1, 5, MODE_ACTIVE);
    // idle of 300 drops active to sleep, then sleep to deep sleep
    push_req(OP_SAMPLE, 821, 0, 16'sh7FFF, 0, 6, 5, MODE_ACTIVE);
    push_req(OP_SAMPLE, 821, 0, 16'sh7FFF, 0, 6, 5, MODE_ACTIVE);
    // motion in deep sleep keeps the mode
    push_req(OP_SAMPLE, 821, 16'sh8000, 16'sh7FFF, 0, 7, 0, MODE_ACTIVE);
    // forcing, a dropped force target and the unused operation code
    push_req(OP_FORCE,  0, 0, 0, 0, 0, 0, MODE_SLEEP);
    push_req(OP_FORCE,  0, 0, 0, 0, 0, 0, MODE_UNDEFINED);
    push_req(OP_UNUSED, 16'sh7FFF, -1, 16'sh8000, 31, 63, 63, MODE_DEEP);
    push_req(OP_FORCE,  0, 0, 0, 0, 0, 0, MODE_ACTIVE);
    // baseline one second before midnight, then idle across the day edge
    push_req(OP_START,  16'sh7FFF, 16'sh8000, -1, 23, 59, 59, MODE_ACTIVE);
    push_req(OP_SAMPLE, 16'sh7FFF, 16'sh8000, -1, 0, 0, 5, MODE_ACTIVE);
    // out-of-range rtc fields fold back by one day
    push_req(OP_SAMPLE, 16'sh7FFF, 16'sh8000, -1, 31, 63, 63, MODE_ACTIVE);
    push_req(OP_SAMPLE, 16'sh7FFF, 16'sh8000, -1, 24, 0, 0, MODE_ACTIVE);
    // start keeps a forced deep sleep
    push_req(OP_FORCE,  0, 0, 0, 0, 0, 0, MODE_DEEP);
    push_req(OP_START,  0, 0, 0, 12, 34, 56, MODE_ACTIVE);
    push_req(OP_FORCE,  0, 0, 0, 0, 0, 0, MODE_ACTIVE);
    push_req(OP_SAMPLE, 0, 0, 0, 12, 34, 56, MODE_ACTIVE);
    // largest idle: one second short of a day
    push_req(OP_START,  0, 0, 0, 0, 0, 1, MODE_ACTIVE);
    push_req(OP_SAMPLE, 0, 0, 0, 0, 0, 0, MODE_ACTIVE);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          // any change at all is motion, every quiet sample steps down
          write_reg(CFG_MOTION_THRESHOLD, 0);
          write_reg(CFG_LIGHT_TIMEOUT, 0);
          write_reg(CFG_DEEP_TIMEOUT, 0);
          step_max = 5;
        end
        1: begin
          // nothing can move and timeouts beyond a day never fire
          write_reg(CFG_MOTION_THRESHOLD, 65535);
          write_reg(CFG_LIGHT_TIMEOUT, 17'h1FFFF);
          write_reg(CFG_DEEP_TIMEOUT, 86400);
          step_max = 3000;
        end
        2: begin
          write_reg(CFG_MOTION_THRESHOLD, 100);
          write_reg(CFG_LIGHT_TIMEOUT, 10);
          write_reg(CFG_DEEP_TIMEOUT, 40);
          step_max = 4;
        end
        3: begin
          // only a force reaches sleep, then deep sleep comes at once
          write_reg(CFG_MOTION_THRESHOLD, 2000);
          write_reg(CFG_LIGHT_TIMEOUT, 86400);
          write_reg(CFG_DEEP_TIMEOUT, 1);
          step_max = 6;
        end
        4: begin
          // threshold write with the unused top bit set, and the spare index
          write_reg(CFG_MOTION_THRESHOLD, 17'h10005);
          write_reg(CFG_LIGHT_TIMEOUT, 1);
          write_reg(CFG_DEEP_TIMEOUT, 86399);
          write_reg(CFG_UNUSED, CFG_WIDTH'($urandom));
          step_max = 3;
        end
        default: begin
          lt = $urandom_range(1, 60);
          write_reg(CFG_MOTION_THRESHOLD, CFG_WIDTH'($urandom_range(0, 1500)));
          write_reg(CFG_LIGHT_TIMEOUT, CFG_WIDTH'(lt));
          write_reg(CFG_DEEP_TIMEOUT, CFG_WIDTH'($urandom_range(lt, 300)));
          step_max = lt / 3 + 1;
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;

      repeat (RANDOM_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        // rtc mostly creeps forward, sometimes leaps and wraps the day
        step = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 86399) :
                                              $urandom_range(0, step_max);
        clock_sod = (clock_sod + step) % 86400;
        hr = 5'(clock_sod / 3600);
        mn = 6'((clock_sod / 60) % 60);
        sc = 6'(clock_sod % 60);
        if ($urandom_range(0, 24) == 0) {hr, mn, sc} = 17'($urandom);
        for (a = 0; a < 3; a++) axis[a] = SAMPLE_WIDTH'($urandom);
        q = int'(mdl_regs.motion_thr) / 2;
        if (kind < 70) begin
          // quiet: every axis stays within half a threshold of the last one
          op = OP_SAMPLE;
          for (a = 0; a < 3; a++) begin
            r = $urandom_range(0, 2 * q) - q;
            axis[a] = SAMPLE_WIDTH'(int'(sent_axis[a]) + r);
          end
          // now and then one axis lands on the threshold or just past it
          if ($urandom_range(0, 9) == 0) begin
            a = $urandom_range(0, 2);
            r = int'(mdl_regs.motion_thr) + $urandom_range(0, 1);
            axis[a] = SAMPLE_WIDTH'(int'(sent_axis[a]) + ($urandom_range(0, 1) ? r : -r));
          end
        end else if (kind < 85) begin
          // motion on a random subset of axes
          op = OP_SAMPLE;
          for (a = 0; a < 3; a++)
            if ($urandom_range(0, 1)) axis[a] = sent_axis[a];
        end else if (kind < 91) begin
          op = OP_START;
        end else if (kind < 98) begin
          op = OP_FORCE;
        end else begin
          op = OP_UNUSED;
        end
        push_req(op, axis[0], axis[1], axis[2], hr, mn, sc, 2'($urandom));
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && power_rsp_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mips_pkg.sv
hw/rtl/mips_step.sv
hw/rtl/motion_inactivity_power_state.sv
verif/motion_inactivity_power_state_tb.sv
